/* rtl/euler_to_quaternion_defines.svh */
// Assertion macros shared by the Euler to quaternion RTL.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define E2Q_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/e2q_pkg.sv */
// Types, fixed-point constants and the arctangent table of the Euler to quaternion block.
package e2q_pkg;

	// CORDIC x/y width and phase width, both with 30 fraction bits.
	localparam int XW = 33;
	localparam int ZW = 34;

	localparam logic signed [XW-1:0] FX_ONE_X   = 33'sd1073741824;
	localparam logic signed [ZW-1:0] PI_Z       = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Z  = 34'sd1686629713;
	localparam logic signed [ZW-1:0] TWO_PI_Z   = 34'sd6746518852;
	localparam logic [32:0]          TWO_PI_U   = 33'd6746518852;

	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} quat_t;

	// atan(2^-idx) scaled by 2^30, truncated toward zero.
	function automatic logic [29:0] e2q_atan(input int idx);
		case (idx)
			0:  return 30'd843314856;
			1:  return 30'd497837829;
			2:  return 30'd263043836;
			3:  return 30'd133525158;
			4:  return 30'd67021686;
			5:  return 30'd33543515;
			6:  return 30'd16775850;
			7:  return 30'd8388437;
			8:  return 30'd4194282;
			9:  return 30'd2097149;
			10: return 30'd1048575;
			11: return 30'd524287;
			12: return 30'd262143;
			13: return 30'd131071;
			14: return 30'd65535;
			15: return 30'd32767;
			16: return 30'd16383;
			17: return 30'd8191;
			18: return 30'd4095;
			19: return 30'd2047;
			20: return 30'd1023;
			21: return 30'd511;
			22: return 30'd255;
			23: return 30'd127;
			24: return 30'd63;
			25: return 30'd31;
			26: return 30'd15;
			27: return 30'd7;
			28: return 30'd3;
			29: return 30'd1;
			default: return 30'd0;
		endcase
	endfunction

endpackage

/* rtl/e2q_reduce.sv */
// Half-angle range reduction: remainder by two pi, then fold into plus or minus pi/2.
module e2q_reduce import e2q_pkg::*; #(
	parameter int SHIFT  = 0,
	parameter bit NEGATE = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [31:0]   angle,
	output logic                 out_vld,
	output logic signed [ZW-1:0] phase,
	output logic                 flip
);

	localparam int MW = 32 + SHIFT;

	logic [MW-1:0] mag_s [0:SHIFT];
	logic [MW-1:0] mag_nx [0:SHIFT];
	logic          neg_s [0:SHIFT];
	logic          vld_s [0:SHIFT];
	logic [31:0]   mag_in;
	logic [MW-1:0] sub_d;
	logic signed [ZW-1:0] r0, r1, r2;
	logic          fl;
	logic signed [ZW-1:0] phase_q;
	logic          flip_q, vld_q;

	assign mag_in = angle[31] ? 32'(-angle) : 32'(angle);

	// One quotient bit of the remainder by two pi per stage, highest first.
	always_comb begin
		sub_d = '0;
		mag_nx[0] = MW'(mag_in) << SHIFT;
		for (int g = 1; g <= SHIFT; g++) begin
			sub_d = MW'(TWO_PI_U) << (SHIFT - g);
			mag_nx[g] = (mag_s[g-1] >= sub_d) ? mag_s[g-1] - sub_d : mag_s[g-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= SHIFT; g++) vld_s[g] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int g = 1; g <= SHIFT; g++) vld_s[g] <= vld_s[g-1];
			vld_q <= vld_s[SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g <= SHIFT; g++) mag_s[g] <= mag_nx[g];
			neg_s[0] <= NEGATE ? (angle != 32'sd0 && !angle[31]) : angle[31];
			for (int g = 1; g <= SHIFT; g++) neg_s[g] <= neg_s[g-1];
			phase_q <= r2;
			flip_q  <= fl;
		end
	end

	// Remainder has the angle's sign, negated if NEGATE; pi folds flip cos and sin.
	always_comb begin
		r0 = neg_s[SHIFT] ? -ZW'(mag_s[SHIFT]) : ZW'(mag_s[SHIFT]);
		r1 = r0;
		if (r0 > PI_Z) r1 = r0 - TWO_PI_Z;
		if (r0 < -PI_Z) r1 = r0 + TWO_PI_Z;
		r2 = r1;
		fl = 1'b0;
		if (r1 > HALF_PI_Z) begin
			r2 = r1 - PI_Z;
			fl = 1'b1;
		end else if (r1 < -HALF_PI_Z) begin
			r2 = r1 + PI_Z;
			fl = 1'b1;
		end
	end

	assign out_vld = vld_q;
	assign phase   = phase_q;
	assign flip    = flip_q;

endmodule

/* rtl/e2q_cordic.sv */
// Rotation-mode CORDIC pipeline: gain-scaled cos and sin, four iterations a stage.
module e2q_cordic import e2q_pkg::*; #(
	parameter int ITER = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [ZW-1:0] phase,
	input  logic                 flip,
	output logic                 out_vld,
	output logic signed [XW-1:0] cos_v,
	output logic signed [XW-1:0] sin_v
);

	localparam int PER = 4;
	localparam int NST = (ITER + PER - 1) / PER;

	logic signed [XW-1:0] x_s [0:NST];
	logic signed [XW-1:0] y_s [0:NST];
	logic signed [ZW-1:0] z_s [0:NST];
	logic signed [XW-1:0] x_nx [0:NST];
	logic signed [XW-1:0] y_nx [0:NST];
	logic signed [ZW-1:0] z_nx [0:NST];
	logic                 flip_s [0:NST];
	logic                 vld_s [0:NST];
	logic signed [XW-1:0] xa, ya, xt;
	logic signed [ZW-1:0] za;
	logic signed [XW-1:0] cos_q, sin_q;
	logic                 vld_q;

	always_comb begin
		xa = '0;
		ya = '0;
		xt = '0;
		za = '0;
		x_nx[0] = FX_ONE_X;
		y_nx[0] = '0;
		z_nx[0] = phase;
		for (int g = 1; g <= NST; g++) begin
			xa = x_s[g-1];
			ya = y_s[g-1];
			za = z_s[g-1];
			for (int k = 0; k < PER; k++) begin
				if ((g - 1) * PER + k < ITER) begin
					if (!za[ZW-1]) begin
						xt = xa - (ya >>> ((g - 1) * PER + k));
						ya = ya + (xa >>> ((g - 1) * PER + k));
						za = za - $signed(ZW'(e2q_atan((g - 1) * PER + k)));
					end else begin
						xt = xa + (ya >>> ((g - 1) * PER + k));
						ya = ya - (xa >>> ((g - 1) * PER + k));
						za = za + $signed(ZW'(e2q_atan((g - 1) * PER + k)));
					end
					xa = xt;
				end
			end
			x_nx[g] = xa;
			y_nx[g] = ya;
			z_nx[g] = za;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= NST; g++) vld_s[g] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int g = 1; g <= NST; g++) vld_s[g] <= vld_s[g-1];
			vld_q <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g <= NST; g++) begin
				x_s[g] <= x_nx[g];
				y_s[g] <= y_nx[g];
				z_s[g] <= z_nx[g];
			end
			flip_s[0] <= flip;
			for (int g = 1; g <= NST; g++) flip_s[g] <= flip_s[g-1];
			cos_q <= flip_s[NST] ? -x_s[NST] : x_s[NST];
			sin_q <= flip_s[NST] ? -y_s[NST] : y_s[NST];
		end
	end

	assign out_vld = vld_q;
	assign cos_v   = cos_q;
	assign sin_v   = sin_q;

endmodule

/* rtl/e2q_qmul.sv */
// Two Hamilton products, scaling to 28 fraction bits and the squared norm.
module e2q_qmul import e2q_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [XW-1:0] cz,
	input  logic signed [XW-1:0] sz,
	input  logic signed [XW-1:0] cx,
	input  logic signed [XW-1:0] sx,
	input  logic signed [XW-1:0] cy,
	input  logic signed [XW-1:0] sy,
	output logic                 out_vld,
	output quat_t                quat,
	output logic [63:0]          norm_sq
);

	localparam int P1 = 34;
	localparam int P2 = 35;

	logic signed [P1-1:0] pw_s1, px_s1, py_s1, pz_s1;
	logic signed [XW-1:0] cy_s1, sy_s1;
	logic signed [P2-1:0] t_s2 [0:7];
	logic signed [P2:0]   sw, sx2, sy2, sz2;
	quat_t                q_s3, q_s4, q_s5;
	logic [63:0]          sq_s4 [0:3];
	logic [63:0]          sum_s5;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// Products are floored to 30 fraction bits before summing.
	function automatic logic signed [P1-1:0] fm1(input logic signed [XW-1:0] a,
			input logic signed [XW-1:0] b);
		logic signed [2*XW-1:0] p;
		p = (2*XW)'(a) * (2*XW)'(b);
		return P1'(p >>> 30);
	endfunction

	function automatic logic signed [P2-1:0] fm2(input logic signed [P1-1:0] a,
			input logic signed [XW-1:0] b);
		logic signed [P1+XW-1:0] p;
		p = (P1+XW)'(a) * (P1+XW)'(b);
		return P2'(p >>> 30);
	endfunction

	always_comb begin
		sw  = (P2+1)'(t_s2[0]) - (P2+1)'(t_s2[1]);
		sx2 = (P2+1)'(t_s2[2]) - (P2+1)'(t_s2[3]);
		sy2 = (P2+1)'(t_s2[4]) + (P2+1)'(t_s2[5]);
		sz2 = (P2+1)'(t_s2[6]) + (P2+1)'(t_s2[7]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// qz(heading) * qx(pitch): most terms vanish.
			pw_s1 <= fm1(cz, cx);
			px_s1 <= fm1(cz, sx);
			py_s1 <= fm1(sz, sx);
			pz_s1 <= fm1(sz, cx);
			cy_s1 <= cy;
			sy_s1 <= sy;
			// times qy(roll)
			t_s2[0] <= fm2(pw_s1, cy_s1);
			t_s2[1] <= fm2(py_s1, sy_s1);
			t_s2[2] <= fm2(px_s1, cy_s1);
			t_s2[3] <= fm2(pz_s1, sy_s1);
			t_s2[4] <= fm2(pw_s1, sy_s1);
			t_s2[5] <= fm2(py_s1, cy_s1);
			t_s2[6] <= fm2(px_s1, sy_s1);
			t_s2[7] <= fm2(pz_s1, cy_s1);
			q_s3.w <= 32'(sw >>> 2);
			q_s3.x <= 32'(sx2 >>> 2);
			q_s3.y <= 32'(sy2 >>> 2);
			q_s3.z <= 32'(sz2 >>> 2);
			q_s4 <= q_s3;
			sq_s4[0] <= 64'(64'(q_s3.w) * 64'(q_s3.w));
			sq_s4[1] <= 64'(64'(q_s3.x) * 64'(q_s3.x));
			sq_s4[2] <= 64'(64'(q_s3.y) * 64'(q_s3.y));
			sq_s4[3] <= 64'(64'(q_s3.z) * 64'(q_s3.z));
			q_s5   <= q_s4;
			sum_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2] + sq_s4[3];
		end
	end

	assign out_vld = vld_s5;
	assign quat    = q_s5;
	assign norm_sq = sum_s5;

endmodule

/* rtl/e2q_sqrt.sv */
// Digit-by-digit integer square root of the squared norm, one root bit per stage.
module e2q_sqrt import e2q_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  quat_t       in_quat,
	input  logic [63:0] norm_sq,
	output logic        out_vld,
	output quat_t       quat,
	output logic [31:0] norm
);

	localparam int NS = 32;

	logic [63:0] rem_s [0:NS];
	logic [63:0] rem_nx [0:NS];
	logic [31:0] root_s [0:NS];
	logic [31:0] root_nx [0:NS];
	quat_t       q_s [0:NS];
	logic        vld_s [0:NS];
	logic [65:0] trial;

	// Trial subtrahend is (2*root + 2^k) * 2^k with root holding only bits above k.
	always_comb begin
		trial = '0;
		rem_nx[0]  = norm_sq;
		root_nx[0] = '0;
		for (int g = 1; g <= NS; g++) begin
			trial = (66'(root_s[g-1]) << (NS - g + 1)) | (66'(1) << (2 * (NS - g)));
			if (66'(rem_s[g-1]) >= trial) begin
				rem_nx[g]  = rem_s[g-1] - trial[63:0];
				root_nx[g] = root_s[g-1] | (32'(1) << (NS - g));
			end else begin
				rem_nx[g]  = rem_s[g-1];
				root_nx[g] = root_s[g-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= NS; g++) vld_s[g] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int g = 1; g <= NS; g++) vld_s[g] <= vld_s[g-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g <= NS; g++) begin
				rem_s[g]  <= rem_nx[g];
				root_s[g] <= root_nx[g];
			end
			q_s[0] <= in_quat;
			for (int g = 1; g <= NS; g++) q_s[g] <= q_s[g-1];
		end
	end

	assign out_vld = vld_s[NS];
	assign quat    = q_s[NS];
	assign norm    = root_s[NS];

endmodule

/* rtl/e2q_div.sv */
// Four-lane restoring divider that divides each component by the norm, with rounding.
module e2q_div import e2q_pkg::*; #(
	parameter int FRAC = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  quat_t       in_quat,
	input  logic [31:0] norm,
	output logic        out_vld,
	output quat_t       quat
);

	localparam int QW = FRAC + 1;
	localparam logic [QW-1:0] LIM = QW'(1) << FRAC;

	logic [63:0]        rem_s [0:QW][0:3];
	logic [63:0]        rem_nx [0:QW][0:3];
	logic [QW-1:0]      quo_s [0:QW][0:3];
	logic [QW-1:0]      quo_nx [0:QW][0:3];
	logic signed [31:0] c_s [0:QW][0:3];
	logic signed [31:0] cin [0:3];
	logic [31:0]        n_s [0:QW];
	logic               vld_s [0:QW];
	logic [31:0]        mag;
	logic [63:0]        dsub;
	logic [QW-1:0]      qs;
	logic signed [31:0] res [0:3];
	quat_t              out_q;
	logic               vld_q;

	assign cin[0] = in_quat.w;
	assign cin[1] = in_quat.x;
	assign cin[2] = in_quat.y;
	assign cin[3] = in_quat.z;

	// Dividend carries half the norm so that the quotient rounds half up.
	always_comb begin
		mag  = '0;
		dsub = '0;
		for (int l = 0; l < 4; l++) begin
			mag = cin[l][31] ? 32'(-cin[l]) : 32'(cin[l]);
			rem_nx[0][l] = (64'(mag) << FRAC) + 64'(norm >> 1);
			quo_nx[0][l] = '0;
			for (int g = 1; g <= QW; g++) begin
				dsub = 64'(n_s[g-1]) << (QW - g);
				if (rem_s[g-1][l] >= dsub) begin
					rem_nx[g][l] = rem_s[g-1][l] - dsub;
					quo_nx[g][l] = quo_s[g-1][l] | (QW'(1) << (QW - g));
				end else begin
					rem_nx[g][l] = rem_s[g-1][l];
					quo_nx[g][l] = quo_s[g-1][l];
				end
			end
		end
	end

	// A zero norm passes the unnormalized component through.
	always_comb begin
		qs = '0;
		for (int l = 0; l < 4; l++) begin
			qs = (quo_s[QW][l] > LIM) ? LIM : quo_s[QW][l];
			if (n_s[QW] == 32'd0) res[l] = c_s[QW][l];
			else res[l] = c_s[QW][l][31] ? -32'(qs) : 32'(qs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= QW; g++) vld_s[g] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int g = 1; g <= QW; g++) vld_s[g] <= vld_s[g-1];
			vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g <= QW; g++) begin
				for (int l = 0; l < 4; l++) begin
					rem_s[g][l] <= rem_nx[g][l];
					quo_s[g][l] <= quo_nx[g][l];
				end
			end
			for (int l = 0; l < 4; l++) c_s[0][l] <= cin[l];
			for (int g = 1; g <= QW; g++) c_s[g] <= c_s[g-1];
			n_s[0] <= norm;
			for (int g = 1; g <= QW; g++) n_s[g] <= n_s[g-1];
			out_q.w <= res[0];
			out_q.x <= res[1];
			out_q.y <= res[2];
			out_q.z <= res[3];
		end
	end

	assign out_vld = vld_q;
	assign quat    = out_q;

endmodule

/* rtl/euler_to_quaternion.sv */
// Top level: Euler angles (heading, pitch, roll) to unit quaternion, fully pipelined.
//
// Channel   Dir  Contents
// s_axis    in   heading, pitch, roll angles, signed Q2.29 radians
// m_axis    out  quaternion w, x, y, z, signed Q1.30
//
// One item enters per cycle unless the output stalls. There are (29 - ANGLE_FRAC_BITS)
// + 2 range-reduction stages, ceil(CORDIC_ITERATIONS / 4) + 2 CORDIC stages, 5 product
// stages, 33 square root stages and COMPONENT_FRAC_BITS + 3 divider stages. The depth
// is set by the square root and divider, which resolve one bit per stage. Reset clears
// only the valid bits. A stall at the output holds every stage in place.
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int CORDIC_ITERATIONS   = 24,
	parameter int ANGLE_FRAC_BITS     = 29,
	parameter int COMPONENT_FRAC_BITS = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [95:0]   s_axis_tdata,  // heading_angle, pitch_angle, roll_angle
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);

	`include "euler_to_quaternion_defines.svh"

	localparam int SHIFT = 29 - ANGLE_FRAC_BITS;
	localparam logic signed [31:0] COMP_ONE = 32'sd1 <<< COMPONENT_FRAC_BITS;

	logic                 en;
	logic                 rz_vld, rx_vld, ry_vld;
	logic signed [ZW-1:0] rz_ph, rx_ph, ry_ph;
	logic                 rz_fl, rx_fl, ry_fl;
	logic                 cz_vld, cx_vld, cy_vld;
	logic signed [XW-1:0] cz, sz, cx, sx, cy, sy;
	logic                 qm_vld;
	quat_t                qm_q;
	logic [63:0]          qm_sum;
	logic                 sq_vld;
	quat_t                sq_q;
	logic [31:0]          sq_n;
	quat_t                q_out;

	// The whole pipeline advances unless a finished item is waiting.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	e2q_reduce #(.SHIFT(SHIFT), .NEGATE(1'b1)) u_red_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_axis_tvalid),
		.angle($signed(s_axis_tdata[31:0])),
		.out_vld(rz_vld), .phase(rz_ph), .flip(rz_fl));

	e2q_reduce #(.SHIFT(SHIFT), .NEGATE(1'b0)) u_red_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_axis_tvalid),
		.angle($signed(s_axis_tdata[63:32])),
		.out_vld(rx_vld), .phase(rx_ph), .flip(rx_fl));

	e2q_reduce #(.SHIFT(SHIFT), .NEGATE(1'b0)) u_red_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_axis_tvalid),
		.angle($signed(s_axis_tdata[95:64])),
		.out_vld(ry_vld), .phase(ry_ph), .flip(ry_fl));

	e2q_cordic #(.ITER(CORDIC_ITERATIONS)) u_cor_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(rz_vld), .phase(rz_ph),
		.flip(rz_fl), .out_vld(cz_vld), .cos_v(cz), .sin_v(sz));

	e2q_cordic #(.ITER(CORDIC_ITERATIONS)) u_cor_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(rx_vld), .phase(rx_ph),
		.flip(rx_fl), .out_vld(cx_vld), .cos_v(cx), .sin_v(sx));

	e2q_cordic #(.ITER(CORDIC_ITERATIONS)) u_cor_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(ry_vld), .phase(ry_ph),
		.flip(ry_fl), .out_vld(cy_vld), .cos_v(cy), .sin_v(sy));

	e2q_qmul u_qmul (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(cz_vld),
		.cz(cz), .sz(sz), .cx(cx), .sx(sx), .cy(cy), .sy(sy),
		.out_vld(qm_vld), .quat(qm_q), .norm_sq(qm_sum));

	e2q_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(qm_vld), .in_quat(qm_q),
		.norm_sq(qm_sum), .out_vld(sq_vld), .quat(sq_q), .norm(sq_n));

	e2q_div #(.FRAC(COMPONENT_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(sq_vld), .in_quat(sq_q),
		.norm(sq_n), .out_vld(m_axis_tvalid), .quat(q_out));

	assign m_axis_tdata = {q_out.z, q_out.y, q_out.x, q_out.w};

	// The three angle lanes run in lockstep.
	`E2Q_ASSERT_NOW(a_lanes_aligned, rz_vld || rx_vld || ry_vld || cx_vld || cy_vld, (rz_vld == rx_vld) && (rz_vld == ry_vld) && (cz_vld == cx_vld) && (cz_vld == cy_vld), "angle lanes out of step")
	`E2Q_ASSERT_NOW(a_unit_range, m_axis_tvalid, (q_out.w <= COMP_ONE) && (q_out.w >= -COMP_ONE) && (q_out.x <= COMP_ONE) && (q_out.x >= -COMP_ONE) && (q_out.y <= COMP_ONE) && (q_out.y >= -COMP_ONE) && (q_out.z <= COMP_ONE) && (q_out.z >= -COMP_ONE), "component beyond unit range")
	`E2Q_ASSERT_NOW(a_zero_norm, sq_vld && (sq_n == 32'd0), sq_q == '0, "zero norm with nonzero component")
	`E2Q_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready && sq_vld, sq_vld && $stable(sq_n), "pipeline moved during stall")

endmodule
